### src/stn_pkg.sv
package stn_pkg;

    // Character codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_EQ    = 8'h3D;

    // Result slots per accepted byte: two per processed byte plus the end marker
    localparam int NSLOT   = 5;
    localparam int SLOT_W  = $clog2(NSLOT);
    localparam int CNT_W   = $clog2(NSLOT + 1);

    // Per-line scanner flags
    typedef struct packed {
        logic inside_quote;
        logic previous_was_space;
        logic line_started;
        logic skipping_comment;
        logic pending_space;
    } norm_state_t;

    // Outcome of one processed byte: new flags and up to two emitted bytes
    typedef struct packed {
        norm_state_t          st;
        logic [1:0][7:0]      b;
        logic [1:0]           cnt;
    } proc_res_t;

    // One result item
    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       end_of_text;
        logic       unterminated_quote;
    } out_item_t;

    // All results caused by one accepted byte
    typedef struct packed {
        out_item_t [NSLOT-1:0] slot;
        logic [CNT_W-1:0]      cnt;
    } res_bundle_t;

    function automatic logic is_alnum(logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic is_special(logic [7:0] c);
        return c == CH_PLUS || c == CH_MINUS || c == CH_SLASH || c == CH_STAR ||
               c == CH_EQ || c == CH_LPAR || c == CH_RPAR;
    endfunction

    function automatic proc_res_t push_byte(proc_res_t r, logic [7:0] c);
        proc_res_t o;
        o = r;
        o.b[r.cnt[0]] = c;
        o.cnt = r.cnt + 2'd1;
        return o;
    endfunction

    // Owe one space; open the line first and pay an earlier owed space
    function automatic proc_res_t put_space(proc_res_t r);
        proc_res_t o;
        o = r;
        if (!o.st.line_started)
        begin
            o = push_byte(o, CH_LF);
            o.st.line_started = 1'b1;
        end
        if (o.st.pending_space)
            o = push_byte(o, CH_SPACE);
        o.st.pending_space = 1'b1;
        return o;
    endfunction

    function automatic proc_res_t put_char(proc_res_t r, logic [7:0] c);
        proc_res_t o;
        o = r;
        if (o.st.line_started)
        begin
            if (o.st.pending_space)
                o = push_byte(o, CH_SPACE);
        end
        else
        begin
            o = push_byte(o, CH_LF);
            o.st.line_started = 1'b1;
        end
        o.st.pending_space = 1'b0;
        o = push_byte(o, c);
        return o;
    endfunction

    // Process byte c with lookahead nx
    function automatic proc_res_t proc_byte(norm_state_t s, logic [7:0] c, logic [7:0] nx);
        proc_res_t r;
        logic      sp;
        r.st  = s;
        r.b   = '0;
        r.cnt = 2'd0;
        sp    = (c == CH_SPACE) || (c == CH_TAB);
        // CR right before LF is dropped
        if (!(c == CH_CR && nx == CH_LF))
        begin
            if (c == CH_QUOTE && !s.skipping_comment)
                r.st.inside_quote = !s.inside_quote;
            if (c == CH_LF)
            begin
                if (r.st.inside_quote && !r.st.skipping_comment)
                    r = put_space(r);
                else
                begin
                    r.st.previous_was_space = 1'b0;
                    r.st.line_started       = 1'b0;
                    r.st.skipping_comment   = 1'b0;
                    r.st.pending_space      = 1'b0;
                    r.st.inside_quote       = 1'b0;
                end
            end
            else if (!r.st.skipping_comment &&
                     !(sp && (!r.st.line_started || r.st.previous_was_space)))
            begin
                r.st.previous_was_space = sp;
                if (sp)
                    r = put_space(r);
                else if (c == CH_SLASH && nx == CH_SLASH && !r.st.inside_quote)
                    r.st.skipping_comment = 1'b1;
                else
                begin
                    r = put_char(r, c);
                    if (!r.st.inside_quote &&
                        ((is_alnum(c) && is_special(nx)) || (is_alnum(nx) && is_special(c))))
                        r = put_space(r);
                end
            end
        end
        return r;
    endfunction

endpackage

### src/stn_res_buf.sv
module stn_res_buf
    import stn_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,       // a new bundle is taken this cycle
    input  res_bundle_t bundle,
    output logic        can_load,   // buffer is empty or drains its last item now
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // out_byte
    output logic [1:0]  m_tuser,    // [0] has_byte, [1] unterminated_quote
    output logic        m_tlast     // end_of_text
);

    out_item_t [NSLOT-1:0] slot_reg;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [SLOT_W-1:0]     idx_reg, idx_next;
    logic                  last_item;
    out_item_t             cur;

    assign cur       = slot_reg[idx_reg];
    assign m_tvalid  = (cnt_reg != '0);
    assign last_item = (CNT_W'(idx_reg) + CNT_W'(1) == cnt_reg);
    assign can_load  = !m_tvalid || (m_tready && last_item);

    assign m_tdata = cur.out_byte;
    assign m_tuser = {cur.unterminated_quote, cur.has_byte};
    assign m_tlast = cur.end_of_text;

    // Read pointer and fill count
    always_comb
    begin
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        if (m_tvalid && m_tready)
        begin
            if (last_item)
            begin
                cnt_next = '0;
                idx_next = '0;
            end
            else
                idx_next = idx_reg + SLOT_W'(1);
        end
        if (load)
        begin
            cnt_next = bundle.cnt;
            idx_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            idx_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (load)
            slot_reg <= bundle.slot;
    end

endmodule

### src/script_text_normalizer.sv
// Script text normalizer.
// Input stream (s_*): one raw script byte per transfer in s_tdata, s_tlast on
// the final byte of a text. Output stream (m_*): normalized bytes in m_tdata
// with m_tuser[0] set; the end of a text is a marker transfer with
// m_tuser[0] clear, m_tlast set and m_tuser[1] flagging an open quote.
// One byte is held back as lookahead, so a byte's results come out when the
// next byte (or the last byte) is taken.
// Latency: results of an accepted byte show on m_* in the next cycle.
// Throughput: one input byte per cycle while m_tready is high and each byte
// yields at most one output transfer; a byte yielding N results (up to 5 on
// the last byte) holds the single result buffer until its last result drains,
// which sets the rate. Bytes that yield nothing never touch the output.
// Stall: while m_tready is low the result buffer holds and s_tready drops
// once the buffer cannot be emptied in the same cycle; nothing is lost.
// Reset: rst_n clears the scanner flags, the held byte and the buffer;
// the block is ready as soon as reset is released. After each end marker
// the scanner is back in its reset state.
module script_text_normalizer
    import stn_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // in_byte
    input  logic       s_tlast,    // in_last
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // out_byte
    output logic [1:0] m_tuser,    // [0] has_byte, [1] unterminated_quote
    output logic       m_tlast     // end_of_text
);

    norm_state_t st_reg, st_next;
    logic [7:0]  held_byte_reg, held_byte_next;
    logic        held_valid_reg, held_valid_next;
    logic        accept, can_load;
    proc_res_t   p1, p2;
    logic [CNT_W-1:0] n1, n2;
    res_bundle_t bundle;

    assign accept = s_tvalid && s_tready;
    assign s_tready = can_load;

    // Held byte with incoming byte as lookahead, then last byte with NUL lookahead
    assign p1 = proc_byte(st_reg, held_byte_reg, s_tdata);
    assign p2 = proc_byte(held_valid_reg ? p1.st : st_reg, s_tdata, CH_NUL);
    assign n1 = held_valid_reg ? CNT_W'(p1.cnt) : '0;
    assign n2 = s_tlast ? CNT_W'(p2.cnt) : '0;

    // Pack the results of this byte into the bundle
    always_comb
    begin
        logic [CNT_W-1:0] k;
        k = '0;
        for (int i = 0; i < NSLOT; i++)
        begin
            k = CNT_W'(i) - n1;
            if (CNT_W'(i) < n1)
                bundle.slot[i] = '{out_byte: p1.b[i % 2], has_byte: 1'b1,
                                   end_of_text: 1'b0, unterminated_quote: 1'b0};
            else if (CNT_W'(i) < n1 + n2)
                bundle.slot[i] = '{out_byte: p2.b[k[0]], has_byte: 1'b1,
                                   end_of_text: 1'b0, unterminated_quote: 1'b0};
            else
                bundle.slot[i] = '{out_byte: CH_NUL, has_byte: 1'b0,
                                   end_of_text: 1'b1,
                                   unterminated_quote: p2.st.inside_quote};
        end
        bundle.cnt = n1 + n2 + (s_tlast ? CNT_W'(1) : CNT_W'(0));
    end

    // Scanner state update
    always_comb
    begin
        st_next         = st_reg;
        held_byte_next  = held_byte_reg;
        held_valid_next = held_valid_reg;
        if (accept)
        begin
            if (s_tlast)
            begin
                st_next         = '0;
                held_byte_next  = CH_NUL;
                held_valid_next = 1'b0;
            end
            else
            begin
                st_next         = held_valid_reg ? p1.st : st_reg;
                held_byte_next  = s_tdata;
                held_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg         <= '0;
            held_byte_reg  <= CH_NUL;
            held_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg         <= st_next;
            held_byte_reg  <= held_byte_next;
            held_valid_reg <= held_valid_next;
        end
    end

    // Result buffer and output serializer
    stn_res_buf u_res_buf (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (accept),
        .bundle   (bundle),
        .can_load (can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
